[hw/rtl/tmls_pkg.sv]
// shared types and constants for the terminal multiplexer line scanner
// no dependencies
`default_nettype none

package tmls_pkg;

  // i/o operation carried in the input item's tuser
  typedef enum logic [2:0] {
    OP_STATUS = 3'd0,
    OP_CTRL   = 3'd1,
    OP_DWRITE = 3'd2,
    OP_DREAD  = 3'd3,
    OP_POLL   = 3'd4
  } op_t;

  // transmit conversion modes
  localparam logic [1:0] MODE_UPPER = 2'd0;
  localparam logic [1:0] MODE_7BIT  = 2'd1;
  localparam logic [1:0] MODE_8BIT  = 2'd2;
  localparam logic [1:0] MODE_PRINT = 2'd3;

  // control write bits
  localparam int CTL_SCAN_RST_BIT = 3;
  localparam int CTL_CLEAR_BIT    = 5;

  // data write bits
  localparam int DW_ADDR_BIT   = 24;
  localparam int DW_TXOFF_BIT  = 8;
  localparam int DW_READY_BIT  = 7;
  localparam int DW_NOHANG_BIT = 6;

  localparam int DATA_KEEP_W = 25;
  localparam int READ_W      = 23;
  localparam int POS_W       = 5;

  // control characters that pass printable mode
  localparam logic [31:0] PRINT_CTRL = 32'h0000_2780;

  localparam logic [READ_W-1:0] RD_CHAR_FLAG = 23'o400;
  localparam logic [READ_W-1:0] RD_MODEM_ON  = 23'o104;

  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic last;
    logic out_load;
  } tmls_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_full;
  } tmls_stat_t;

endpackage

`default_nettype wire

[hw/rtl/terminal_mux_line_scanner.sv]
// top level of the terminal multiplexer line scanner
// instantiates tmls_ctrl and tmls_dpath, depends on tmls_pkg
`default_nettype none

// One i/o item at a time: an item is taken, executed in the next cycle, and
// the scanner then visits one position per cycle until it finds a receive or
// transmit flag or has looked at 2*LINES positions; the result then moves to
// the output register. The scanner's one-position-per-cycle walk sets the time
// an item takes from one acceptance to the earliest next acceptance; the
// hand-off waits longer while the output register still holds an unaccepted
// result. A finished result waits in the output register while the next item
// is taken. output_mode may be written only while no item is in flight.
module terminal_mux_line_scanner #(
  parameter int LINES = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // data, rx_avail, rx_char, rx_break, rx_more, line_connected,
  // new_conn_valid, new_conn_line, zero fill
  input  wire logic [tmls_pkg::IN_DATA_W-1:0]     in_tdata,
  // op
  input  wire logic [2:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // read_data, irq_request, irq_level, tx_valid, tx_line, tx_char,
  // hangup_valid, hangup_line, rx_take, rx_line, zero fill
  output logic [tmls_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  // output_mode
  input  wire logic [1:0]                         cfg_wdata
);

  tmls_pkg::tmls_cmd_t  cmd;
  tmls_pkg::tmls_stat_t stat;

  tmls_ctrl #(
    .LINES(LINES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tready(out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmls_dpath #(
    .LINES(LINES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/tmls_ctrl.sv]
// sequencing state machine: accept, execute, scanner steps, result hand-off
// depends on tmls_pkg
`default_nettype none

module tmls_ctrl #(
  parameter int LINES = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic                  out_tready,
  input  wire tmls_pkg::tmls_stat_t  stat,
  output tmls_pkg::tmls_cmd_t        cmd
);

  localparam int CNT_W = $clog2(2 * LINES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * LINES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.load = in_tvalid && in_tready_r;
      S_EXEC: cmd.exec = 1'b1;
      S_SCAN: begin
        cmd.step = 1'b1;
        cmd.last = (cnt_r == CNT_LAST);
      end
      S_DONE: cmd.out_load = !stat.out_full || out_tready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      in_tready_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          in_tready_r <= 1'b1;
          if (in_tvalid && in_tready_r) begin
            in_tready_r <= 1'b0;
            state_r     <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.hit || cnt_r == CNT_LAST) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (!stat.out_full || out_tready) begin
            in_tready_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r <= CNT_LAST)
    else $error("scanner ran past its step limit");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && (stat.hit || cmd.last) |=> state_r == S_DONE && !in_tready_r)
    else $error("scan end did not reach hand-off");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r |-> state_r == S_IDLE)
    else $error("input ready outside idle");

endmodule

`default_nettype wire

[hw/rtl/tmls_dpath.sv]
// line state, i/o operation execution, scanner step and result register
// depends on tmls_pkg
`default_nettype none

module tmls_dpath #(
  parameter int LINES = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tmls_pkg::tmls_cmd_t                 cmd,
  output tmls_pkg::tmls_stat_t                     stat,
  input  wire logic [tmls_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic [2:0]                          in_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_wdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tmls_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam int PW = tmls_pkg::POS_W;
  localparam int RW = tmls_pkg::READ_W;
  localparam logic [PW:0]   LINES6 = (PW + 1)'(LINES);
  localparam logic [PW-1:0] LINES5 = PW'(LINES);

  // captured item
  tmls_pkg::op_t                        op_r;
  logic [tmls_pkg::DATA_KEEP_W-1:0]     data_r;
  logic [7:0]                           avail_r, avail_nxt;
  logic [6:0]                           rxc_r;
  logic                                 brk_r, more_r;
  logic [7:0]                           conn_r;
  logic                                 ncv_r;
  logic [2:0]                           ncl_r;

  // block state
  logic [1:0]       mode_r;
  logic [2:0]       pi_r, pi_nxt;
  logic             rcv_r, rcv_nxt, xmt_r, xmt_nxt;
  logic [PW-1:0]    scan_r, scan_nxt;
  logic [LINES-1:0] txen_r, txen_nxt;
  logic [31:0]      ready_r, ready_nxt;
  logic [LINES-1:0] seen_r, seen_nxt;

  // per-item result
  logic [RW-1:0] rd_r, rd_nxt;
  logic          found_r, found_nxt;
  logic          txv_r, txv_nxt;
  logic [2:0]    txl_r, txl_nxt;
  logic [7:0]    txc_r, txc_nxt;
  logic          hv_r, hv_nxt;
  logic [2:0]    hl_r, hl_nxt;
  logic          take_r, take_nxt;
  logic [2:0]    rl_r, rl_nxt;

  // output register
  logic                              out_valid_r;
  logic [tmls_pkg::OUT_DATA_W-1:0]   out_data_r;

  function automatic logic [8:0] convert_tx(input logic [1:0] md, input logic [7:0] d);
    logic [7:0] c;
    logic       ok;
    c  = d;
    ok = 1'b1;
    if (md != tmls_pkg::MODE_8BIT) begin
      c[7] = 1'b0;
      if (md == tmls_pkg::MODE_UPPER) begin
        if (c >= 8'o141 && c <= 8'o172) c = c - 8'o40;
        if (c >= 8'o140) ok = 1'b0;
      end
      if (md == tmls_pkg::MODE_UPPER || md == tmls_pkg::MODE_PRINT) begin
        if (c == 8'o177 || (c < 8'o40 && !tmls_pkg::PRINT_CTRL[c[4:0]])) ok = 1'b0;
      end
    end
    return {ok, c};
  endfunction

  logic [PW:0]   wpos, widx;
  logic [PW-1:0] sidx;
  logic [8:0]    conv;
  logic          s_line, s_modem, s_conn, s_seen, s_drop, s_avail, s_rcv, s_xmt;
  logic [31:0]   s_mask;

  always_comb begin
    avail_nxt = avail_r;
    pi_nxt    = pi_r;
    rcv_nxt   = rcv_r;
    xmt_nxt   = xmt_r;
    scan_nxt  = scan_r;
    txen_nxt  = txen_r;
    ready_nxt = ready_r;
    seen_nxt  = seen_r;
    rd_nxt    = rd_r;
    found_nxt = found_r;
    txv_nxt   = txv_r;
    txl_nxt   = txl_r;
    txc_nxt   = txc_r;
    hv_nxt    = hv_r;
    hl_nxt    = hl_r;
    take_nxt  = take_r;
    rl_nxt    = rl_r;

    wpos = data_r[tmls_pkg::DW_ADDR_BIT] ? data_r[23:18] : {1'b0, scan_r};
    widx = wpos - LINES6;
    conv = convert_tx(mode_r, data_r[7:0]);

    // scanner position under test
    sidx    = scan_r - LINES5;
    s_line  = scan_r < LINES5;
    s_modem = !s_line && sidx < LINES5;
    s_conn  = sidx < PW'(8) && conn_r[sidx[2:0]];
    s_seen  = |(seen_r & (LINES'(1) << sidx));
    s_drop  = s_modem && s_seen && !s_conn;
    s_avail = s_line && scan_r < PW'(8) && avail_r[scan_r[2:0]];
    s_mask  = 32'd1 << scan_r;
    s_rcv   = ready_r[scan_r] || s_drop || s_avail;
    s_xmt   = s_line && |(txen_r & (LINES'(1) << scan_r));

    if (cmd.exec) begin
      rd_nxt    = '0;
      found_nxt = 1'b0;
      txv_nxt   = 1'b0;
      txl_nxt   = '0;
      txc_nxt   = '0;
      hv_nxt    = 1'b0;
      hl_nxt    = '0;
      take_nxt  = 1'b0;
      rl_nxt    = '0;
      unique case (op_r)
        tmls_pkg::OP_STATUS: rd_nxt = RW'({xmt_r, rcv_r, pi_r});
        tmls_pkg::OP_CTRL: begin
          pi_nxt = data_r[2:0];
          if (data_r[tmls_pkg::CTL_SCAN_RST_BIT]) scan_nxt = '0;
          if (data_r[tmls_pkg::CTL_CLEAR_BIT]) begin
            scan_nxt  = '0;
            rcv_nxt   = 1'b0;
            xmt_nxt   = 1'b0;
            txen_nxt  = '0;
            ready_nxt = '0;
            seen_nxt  = '0;
          end
        end
        tmls_pkg::OP_DWRITE: begin
          if (wpos < LINES6) begin
            if (data_r[tmls_pkg::DW_TXOFF_BIT]) begin
              txen_nxt = txen_r & ~(LINES'(1) << wpos);
            end else begin
              txv_nxt  = conv[8];
              txl_nxt  = conv[8] ? wpos[2:0] : 3'd0;
              txc_nxt  = conv[8] ? conv[7:0] : 8'd0;
              txen_nxt = txen_r | (LINES'(1) << wpos);
            end
          end else begin
            if (data_r[tmls_pkg::DW_READY_BIT] && !wpos[PW]) begin
              ready_nxt = ready_r | (32'd1 << wpos[PW-1:0]);
            end
            if (!data_r[tmls_pkg::DW_NOHANG_BIT] && widx < LINES6 && widx < 6'd8
                && conn_r[widx[2:0]]) begin
              hv_nxt = 1'b1;
              hl_nxt = widx[2:0];
            end
          end
        end
        tmls_pkg::OP_DREAD: begin
          rd_nxt = {scan_r, 18'd0};
          if (s_line) begin
            if (scan_r < PW'(8) && avail_r[scan_r[2:0]]) begin
              rd_nxt   = rd_nxt | tmls_pkg::RD_CHAR_FLAG | RW'(brk_r ? 7'd0 : rxc_r);
              take_nxt = 1'b1;
              rl_nxt   = scan_r[2:0];
              avail_nxt[scan_r[2:0]] = more_r;
            end
            ready_nxt = ready_r & ~s_mask;
            if (scan_r < PW'(8) && avail_nxt[scan_r[2:0]]) ready_nxt = ready_nxt | s_mask;
          end else begin
            if (s_modem && s_conn) rd_nxt = rd_nxt | tmls_pkg::RD_MODEM_ON;
            ready_nxt = ready_r & ~s_mask;
          end
        end
        tmls_pkg::OP_POLL: begin
          if (ncv_r && {1'b0, ncl_r} < 4'(LINES)) begin
            seen_nxt  = seen_r | (LINES'(1) << ncl_r);
            ready_nxt = ready_r | (32'd1 << (PW'(ncl_r) + LINES5));
          end
        end
        default: rd_nxt = '0;
      endcase
    end

    if (cmd.step) begin
      if (s_drop) seen_nxt = seen_r & ~(LINES'(1) << sidx);
      if (s_drop || s_avail) ready_nxt = ready_r | s_mask;
      rcv_nxt   = s_rcv;
      xmt_nxt   = s_xmt;
      found_nxt = s_rcv || s_xmt;
      if (!(s_rcv || s_xmt) && !cmd.last) scan_nxt = scan_r + 1'b1;
    end
  end

  assign stat.hit      = cmd.step && (s_rcv || s_xmt);
  assign stat.out_full = out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= tmls_pkg::op_t'(in_tuser);
      data_r <= in_tdata[tmls_pkg::DATA_KEEP_W-1:0];
      rxc_r  <= in_tdata[50:44];
      brk_r  <= in_tdata[52];
      more_r <= in_tdata[53];
      conn_r <= in_tdata[61:54];
      ncv_r  <= in_tdata[62];
      ncl_r  <= in_tdata[65:63];
    end
    if (cmd.load) begin
      avail_r <= in_tdata[43:36];
    end else begin
      avail_r <= avail_nxt;
    end
    rd_r    <= rd_nxt;
    found_r <= found_nxt;
    txv_r   <= txv_nxt;
    txl_r   <= txl_nxt;
    txc_r   <= txc_nxt;
    hv_r    <= hv_nxt;
    hl_r    <= hl_nxt;
    take_r  <= take_nxt;
    rl_r    <= rl_nxt;
    if (cmd.out_load) begin
      out_data_r <= {1'b0, rl_r, take_r, hl_r, hv_r, txc_r, txl_r, txv_r,
                     (found_r ? pi_r : 3'd0), found_r, rd_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tmls_pkg::MODE_7BIT;
      pi_r        <= '0;
      rcv_r       <= 1'b0;
      xmt_r       <= 1'b0;
      scan_r      <= '0;
      txen_r      <= '0;
      ready_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      pi_r    <= pi_nxt;
      rcv_r   <= rcv_nxt;
      xmt_r   <= xmt_nxt;
      scan_r  <= scan_nxt;
      txen_r  <= txen_nxt;
      ready_r <= ready_nxt;
      seen_r  <= seen_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_tready)
    else $error("result register overwritten");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $countones({txv_r, hv_r, take_r}) <= 1)
    else $error("more than one line action in one item");

  a_irq_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_data_r[23] || out_data_r[26:24] == 3'd0)
    else $error("interrupt level without request");

endmodule

`default_nettype wire
